// ===== src/bcc_pkg.sv =====
// shared types, constants and register codes for the button click classifier
package bcc_pkg;

    // number of buttons tracked in the state memory
    localparam int NUM_BUTTONS = 4;
    localparam int ADDR_W      = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    // field widths
    localparam int INDEX_W   = 2;
    localparam int DBC_W     = 4;
    localparam int TICK_W    = 8;
    localparam int PRESS_W   = 2;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_SAMPLES     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TICKS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_WINDOW_TICKS = 2'd2;

    // configuration reset values
    localparam logic [DBC_W-1:0]  DEBOUNCE_RESET = 4'd3;
    localparam logic [TICK_W-1:0] LONG_RESET     = 8'd30;
    localparam logic [TICK_W-1:0] WINDOW_RESET   = 8'd15;

    // counter limits
    localparam logic [TICK_W-1:0]  TICK_MAX  = 8'd255;
    localparam logic [PRESS_W-1:0] PRESS_MAX = 2'd3;

    // per-button click phase
    typedef enum logic [2:0] {
        PH_IDLE     = 3'b001,
        PH_PRESSED  = 3'b010,
        PH_RELEASED = 3'b100
    } phase_t;

    // event codes on the result channel
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_LONG   = 2'd1,
        EV_SINGLE = 2'd2,
        EV_DOUBLE = 2'd3
    } event_t;

    // one entry of the state memory
    typedef struct packed {
        logic               stable_level;
        logic [DBC_W-1:0]   debounce_count;
        phase_t             phase;
        logic [TICK_W-1:0]  tick_count;
        logic [PRESS_W-1:0] press_count;
    } bcc_state_t;

    localparam int STATE_W = $bits(bcc_state_t);

    localparam bcc_state_t STATE_RESET = '{
        stable_level:   1'b1,
        debounce_count: '0,
        phase:          PH_IDLE,
        tick_count:     '0,
        press_count:    '0
    };

    // configuration registers as seen by the update logic
    typedef struct packed {
        logic [DBC_W-1:0]  debounce_samples;
        logic [TICK_W-1:0] long_press_ticks;
        logic [TICK_W-1:0] release_window_ticks;
    } bcc_cfg_t;

endpackage

// ===== src/bcc_ram.sv =====
// generic single-write, single-read ram with registered read data
module bcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/bcc_update.sv =====
// per-tick update of one button's state: tick count, debounce, click phase
module bcc_update (
    input  bcc_pkg::bcc_cfg_t   cfg,
    input  bcc_pkg::bcc_state_t cur,
    input  logic                raw_level,
    output bcc_pkg::bcc_state_t nxt,
    output bcc_pkg::event_t     ev
);
    import bcc_pkg::*;

    always_comb begin
        logic [DBC_W:0] dbc_inc;
        bcc_state_t     st;

        st      = cur;
        ev      = EV_NONE;
        dbc_inc = {1'b0, cur.debounce_count} + 1'b1;

        // tick counting while not idle, saturating
        if (cur.phase != PH_IDLE && cur.tick_count != TICK_MAX) begin
            st.tick_count = cur.tick_count + 1'b1;
        end

        // debounce: take the new level after enough differing samples
        if (cur.stable_level != raw_level) begin
            if (dbc_inc >= {1'b0, cfg.debounce_samples}) begin
                st.stable_level   = raw_level;
                st.debounce_count = '0;
            end else begin
                st.debounce_count = dbc_inc[DBC_W-1:0];
            end
        end else begin
            st.debounce_count = '0;
        end

        // click phase machine
        unique case (cur.phase)
            PH_IDLE: begin
                if (!st.stable_level) begin
                    st.tick_count  = '0;
                    st.press_count = PRESS_W'(1);
                    st.phase       = PH_PRESSED;
                end
            end
            PH_PRESSED: begin
                if (st.stable_level) begin
                    if (st.tick_count >= cfg.long_press_ticks) begin
                        ev             = EV_LONG;
                        st.press_count = '0;
                    end
                    st.tick_count = '0;
                    st.phase      = PH_RELEASED;
                end
            end
            PH_RELEASED: begin
                if (st.tick_count >= cfg.release_window_ticks) begin
                    st.phase = PH_IDLE;
                    if (st.press_count == PRESS_W'(1)) begin
                        ev = EV_SINGLE;
                    end else if (st.press_count == PRESS_W'(2)) begin
                        ev = EV_DOUBLE;
                    end
                end else if (!st.stable_level) begin
                    if (st.press_count != PRESS_MAX) begin
                        st.press_count = st.press_count + 1'b1;
                    end
                    st.tick_count = '0;
                    st.phase      = PH_PRESSED;
                end
            end
            default: begin
                st.phase = PH_IDLE;
            end
        endcase

        nxt = st;
    end

endmodule

// ===== src/button_click_classifier.sv =====
// top level: button click classifier with per-button state in a ram
// Each accepted word is one tick sample for one button and gives exactly one result word:
// the button index and an event code (none, long press, single click, double click).
// The block takes one word per cycle unless a waiting result stalls it; each word passes
// the read stage register, then the output register. The state ram is read when the word
// is accepted and written back as its result enters the output register, with a bypass of
// the last written entry when samples of the same button follow each other. Every entry
// starts from its reset state through a valid flag per button, so no clearing pass runs
// after reset. The output register lets a new word enter while a result still waits.
module button_click_classifier (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [bcc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [bcc_pkg::CFG_W-1:0]     cfg_wdata,
    // input words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bcc_pkg::INDEX_W-1:0]   s_button_index,
    input  logic                          s_raw_level,
    // result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bcc_pkg::INDEX_W-1:0]   m_button_index_out,
    output logic [1:0]                    m_event_code
);
    import bcc_pkg::*;

    // configuration registers
    bcc_cfg_t cfg_reg;

    // read stage
    logic                   s1_valid_reg;
    logic [INDEX_W-1:0]     s1_index_reg;
    logic                   s1_level_reg;
    logic                   s1_inrange_reg;
    logic [ADDR_W-1:0]      s1_addr_reg;

    // entry valid flags and write bypass
    logic [NUM_BUTTONS-1:0] entry_valid_reg;
    logic                   byp_valid_reg;
    logic [ADDR_W-1:0]      byp_addr_reg;
    bcc_state_t             byp_state_reg;

    // output register
    logic                   m_valid_reg;
    logic [INDEX_W-1:0]     m_index_reg;
    event_t                 m_event_reg;

    logic                   accept;
    logic                   advance;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   rd_inrange;
    logic [STATE_W-1:0]     ram_rdata;
    bcc_state_t             cur_state;
    bcc_state_t             new_state;
    event_t                 new_event;
    logic                   wr_en;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_samples     <= DEBOUNCE_RESET;
            cfg_reg.long_press_ticks     <= LONG_RESET;
            cfg_reg.release_window_ticks <= WINDOW_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_DEBOUNCE_SAMPLES: begin
                    cfg_reg.debounce_samples <= cfg_wdata[DBC_W-1:0];
                end
                CFG_LONG_PRESS_TICKS: begin
                    cfg_reg.long_press_ticks <= cfg_wdata[TICK_W-1:0];
                end
                CFG_RELEASE_WINDOW_TICKS: begin
                    cfg_reg.release_window_ticks <= cfg_wdata[TICK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // handshake and pipeline advance
    assign advance    = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || advance;
    assign accept     = s_valid && s_ready;
    assign rd_addr    = ADDR_W'(s_button_index);
    assign rd_inrange = int'(s_button_index) < NUM_BUTTONS;
    assign wr_en      = advance && s1_inrange_reg;

    // state memory, one entry per button
    bcc_ram #(
        .WIDTH (STATE_W),
        .DEPTH (NUM_BUTTONS)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (s1_addr_reg),
        .wdata (new_state),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // current entry: bypass, then unwritten entry as reset state, then ram
    always_comb begin
        if (byp_valid_reg && byp_addr_reg == s1_addr_reg) begin
            cur_state = byp_state_reg;
        end else if (!entry_valid_reg[s1_addr_reg]) begin
            cur_state = STATE_RESET;
        end else begin
            cur_state = ram_rdata;
        end
    end

    bcc_update u_update (
        .cfg       (cfg_reg),
        .cur       (cur_state),
        .raw_level (s1_level_reg),
        .nxt       (new_state),
        .ev        (new_event)
    );

    // read stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // read stage payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_index_reg   <= s_button_index;
            s1_level_reg   <= s_raw_level;
            s1_inrange_reg <= rd_inrange;
            s1_addr_reg    <= rd_addr;
        end
    end

    // entry valid flags and bypass control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            byp_valid_reg   <= 1'b0;
        end else if (wr_en) begin
            entry_valid_reg[s1_addr_reg] <= 1'b1;
            byp_valid_reg                <= 1'b1;
        end
    end

    // bypass payload: last entry written back
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            byp_addr_reg  <= s1_addr_reg;
            byp_state_reg <= new_state;
        end
    end

    // output register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_index_reg <= s1_index_reg;
            m_event_reg <= s1_inrange_reg ? new_event : EV_NONE;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_button_index_out = m_index_reg;
    assign m_event_code       = m_event_reg;

endmodule
